// ===== hdl/lrgc_pkg.sv =====
package lrgc_pkg;

  // Field widths of the point stream and of the register file.
  localparam int unsigned RADIUS_W   = 18;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned INDEX_W    = 16;
  localparam int unsigned SLOPE_W    = 16;
  localparam int unsigned LEN_W      = 14;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Derived arithmetic widths. Slopes are Q1.15, so lengths are scaled by 2^15.
  localparam int unsigned Q_FRAC   = 15;
  localparam int unsigned GAP_W    = RADIUS_W + 1;
  localparam int unsigned DIFF_W   = HEIGHT_W + 1;
  localparam int unsigned SCALED_W = HEIGHT_W + Q_FRAC;
  localparam int unsigned LTHR_W   = SLOPE_W + 1 + GAP_W;
  localparam int unsigned GTHR_W   = SLOPE_W + RADIUS_W;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MOUNT_HEIGHT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCAL_SLOPE_TAN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GENERAL_SLOPE_TAN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_HEIGHT_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CONCENTRIC_STEP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RECLASS_GAP       = 3'd5;

  // Register values after reset.
  localparam logic [LEN_W-1:0]   MOUNT_HEIGHT_RST      = 14'd1750;
  localparam logic [SLOPE_W-1:0] LOCAL_SLOPE_TAN_RST   = 16'd4605;
  localparam logic [SLOPE_W-1:0] GENERAL_SLOPE_TAN_RST = 16'd2867;
  localparam logic [LEN_W-1:0]   MIN_HEIGHT_STEP_RST   = 14'd50;
  localparam logic [LEN_W-1:0]   CONCENTRIC_STEP_RST   = 14'd10;
  localparam logic [LEN_W-1:0]   RECLASS_GAP_RST       = 14'd200;

  // Depth of the queue between the front and the back.
  localparam int unsigned FIFO_DEPTH_DEF = 8;

  typedef struct packed {
    logic [LEN_W-1:0]   mount_height;
    logic [SLOPE_W-1:0] local_slope_tan;
    logic [SLOPE_W-1:0] general_slope_tan;
    logic [LEN_W-1:0]   min_height_step;
    logic [LEN_W-1:0]   concentric_step;
    logic [LEN_W-1:0]   reclass_gap;
  } lrgc_cfg_t;

  // Outcome of the slope checks for one point, waiting for its verdict.
  typedef struct packed {
    logic               first;
    logic               local_ok;
    logic               global_ok;
    logic               reclass_ok;
    logic [INDEX_W-1:0] index;
  } lrgc_verdict_t;

endpackage

// ===== hdl/lrgc_front.sv =====
module lrgc_front #(
  parameter int unsigned FIFO_DEPTH = lrgc_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lrgc_pkg::lrgc_cfg_t                 cfg_i,
  input  logic                                push_i,
  output logic                                full_o,
  input  logic [lrgc_pkg::RADIUS_W-1:0]       radius_i,
  input  logic signed [lrgc_pkg::HEIGHT_W-1:0] height_i,
  input  logic                                first_i,
  input  logic [lrgc_pkg::INDEX_W-1:0]        index_i,
  input  logic                                deq_i,
  output logic                                q_push_o,
  output lrgc_pkg::lrgc_verdict_t             q_data_o
);
  import lrgc_pkg::*;

  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  function automatic logic [HEIGHT_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] d);
    logic signed [DIFF_W-1:0] n;
    n = d[DIFF_W-1] ? -d : d;
    return n[HEIGHT_W-1:0];
  endfunction

  logic accept;

  // Credit count: points in the pipeline or the queue. It never exceeds the queue depth.
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign full_o = (cnt_q == CNT_W'(FIFO_DEPTH));
  assign accept = push_i && !full_o;

  always_comb begin
    cnt_d = cnt_q;
    case ({accept, deq_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  // Previous point of the ray, tracked from the input stream alone.
  logic [RADIUS_W-1:0]        last_radius_q;
  logic signed [HEIGHT_W-1:0] last_height_q;
  logic [RADIUS_W-1:0]        last_r_eff;
  logic signed [HEIGHT_W-1:0] last_h_eff;
  logic signed [HEIGHT_W-1:0] neg_sh;

  assign neg_sh     = -$signed({{(HEIGHT_W-LEN_W){1'b0}}, cfg_i.mount_height});
  assign last_r_eff = first_i ? '0 : last_radius_q;
  assign last_h_eff = first_i ? neg_sh : last_height_q;

  // Stage one: radial gap, height differences and gap compares.
  logic signed [GAP_W-1:0]  gap;
  logic signed [DIFF_W-1:0] dprev, dfoot;
  logic                     gt_conc, gt_reclass;

  assign gap   = $signed({1'b0, radius_i}) - $signed({1'b0, last_r_eff});
  assign dprev = $signed({height_i[HEIGHT_W-1], height_i})
               - $signed({last_h_eff[HEIGHT_W-1], last_h_eff});
  assign dfoot = $signed({height_i[HEIGHT_W-1], height_i})
               + $signed({{(DIFF_W-LEN_W){1'b0}}, cfg_i.mount_height});
  assign gt_conc    = gap > $signed({{(GAP_W-LEN_W){1'b0}}, cfg_i.concentric_step});
  assign gt_reclass = gap > $signed({{(GAP_W-LEN_W){1'b0}}, cfg_i.reclass_gap});

  logic                    s1_valid_q;
  logic signed [GAP_W-1:0] s1_gap_q;
  logic [RADIUS_W-1:0]     s1_radius_q;
  logic [HEIGHT_W-1:0]     s1_absprev_q, s1_absfoot_q;
  logic                    s1_gt_conc_q, s1_gt_reclass_q, s1_first_q;
  logic [INDEX_W-1:0]      s1_index_q;

  // Stage two: the two slope products.
  logic signed [LTHR_W-1:0] lthr;
  logic [GTHR_W-1:0]        gthr;

  assign lthr = $signed({1'b0, cfg_i.local_slope_tan}) * s1_gap_q;
  assign gthr = cfg_i.general_slope_tan * s1_radius_q;

  logic                     s2_valid_q;
  logic signed [LTHR_W-1:0] s2_lthr_q;
  logic [GTHR_W-1:0]        s2_gthr_q;
  logic [HEIGHT_W-1:0]      s2_absprev_q, s2_absfoot_q;
  logic                     s2_gt_conc_q, s2_gt_reclass_q, s2_first_q;
  logic [INDEX_W-1:0]       s2_index_q;

  // Control registers of the front.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      last_radius_q <= '0;
      last_height_q <= -$signed({{(HEIGHT_W-LEN_W){1'b0}}, MOUNT_HEIGHT_RST});
    end else begin
      cnt_q      <= cnt_d;
      s1_valid_q <= accept;
      s2_valid_q <= s1_valid_q;
      if (accept) begin
        last_radius_q <= radius_i;
        last_height_q <= height_i;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk_i) begin
    s1_gap_q        <= gap;
    s1_radius_q     <= radius_i;
    s1_absprev_q    <= abs_diff(dprev);
    s1_absfoot_q    <= abs_diff(dfoot);
    s1_gt_conc_q    <= gt_conc;
    s1_gt_reclass_q <= gt_reclass;
    s1_first_q      <= first_i;
    s1_index_q      <= index_i;

    s2_lthr_q       <= lthr;
    s2_gthr_q       <= gthr;
    s2_absprev_q    <= s1_absprev_q;
    s2_absfoot_q    <= s1_absfoot_q;
    s2_gt_conc_q    <= s1_gt_conc_q;
    s2_gt_reclass_q <= s1_gt_reclass_q;
    s2_first_q      <= s1_first_q;
    s2_index_q      <= s1_index_q;
  end

  // Stage three: raise the local threshold after a large gap, then compare.
  logic signed [LTHR_W-1:0] min_thr, thr_eff, prev_s, foot_s;
  logic [GTHR_W-1:0]        foot_g;

  assign min_thr = $signed({{(LTHR_W-LEN_W-Q_FRAC){1'b0}}, cfg_i.min_height_step,
                            {Q_FRAC{1'b0}}});
  assign thr_eff = (s2_gt_conc_q && (s2_lthr_q < min_thr)) ? min_thr : s2_lthr_q;
  assign prev_s  = $signed({{(LTHR_W-SCALED_W){1'b0}}, s2_absprev_q, {Q_FRAC{1'b0}}});
  assign foot_s  = $signed({{(LTHR_W-SCALED_W){1'b0}}, s2_absfoot_q, {Q_FRAC{1'b0}}});
  assign foot_g  = {{(GTHR_W-SCALED_W){1'b0}}, s2_absfoot_q, {Q_FRAC{1'b0}}};

  assign q_push_o            = s2_valid_q;
  assign q_data_o.first      = s2_first_q;
  assign q_data_o.local_ok   = prev_s <= thr_eff;
  assign q_data_o.global_ok  = foot_g <= s2_gthr_q;
  assign q_data_o.reclass_ok = s2_gt_reclass_q && (foot_s <= thr_eff);
  assign q_data_o.index      = s2_index_q;

endmodule

// ===== hdl/lrgc_queue.sv =====
module lrgc_queue #(
  parameter int unsigned FIFO_DEPTH = lrgc_pkg::FIFO_DEPTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  lrgc_pkg::lrgc_verdict_t data_i,
  input  logic                    pop_i,
  output logic                    empty_o,
  output lrgc_pkg::lrgc_verdict_t data_o
);
  import lrgc_pkg::*;

  localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

  function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  lrgc_verdict_t    entries_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign data_o  = entries_q[rd_ptr_q];

  // Pointers and fill level. The front's credit count keeps pushes within the depth.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/lrgc_back.sv =====
module lrgc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           q_empty_i,
  input  lrgc_pkg::lrgc_verdict_t        q_data_i,
  output logic                           q_pop_o,
  input  logic                           pop_i,
  output logic                           empty_o,
  output logic                           is_ground_o,
  output logic [lrgc_pkg::INDEX_W-1:0]   index_out_o
);
  import lrgc_pkg::*;

  logic               last_ground_q;
  logic               out_valid_q;
  logic               out_ground_q;
  logic [INDEX_W-1:0] out_index_q;
  logic               carry_ground;
  logic               ground;

  // Take the next point whenever the output register is free or being emptied.
  assign q_pop_o = !q_empty_i && (!out_valid_q || pop_i);

  // Verdict: the only part that depends on the previous point's outcome.
  assign carry_ground = q_data_i.first ? 1'b0 : last_ground_q;
  assign ground       = q_data_i.local_ok ? (carry_ground || q_data_i.global_ok)
                                          : q_data_i.reclass_ok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_ground_q <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (q_pop_o) begin
        last_ground_q <= ground;
        out_valid_q   <= 1'b1;
      end else if (pop_i) begin
        out_valid_q   <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_ground_q <= ground;
      out_index_q  <= q_data_i.index;
    end
  end

  assign empty_o     = !out_valid_q;
  assign is_ground_o = out_ground_q;
  assign index_out_o = out_index_q;

endmodule

// ===== hdl/lidar_ray_ground_classifier.sv =====
// Ray-based ground classifier for a stream of lidar points.
//
// Points enter through a queue-style port: a transaction takes place at a clock
// edge with push high and full low. Within a ray the points come sorted by
// radius, and first_of_ray_i marks the first point of each ray. Every point gives
// exactly one verdict, in order, read through a second queue-style port: the
// oldest verdict shows while empty is low and leaves at an edge with pop high.
//
// A point accepted at an edge passes the stage-one and stage-two registers, the
// inner queue and the output register before its verdict shows. One point per
// cycle is sustained while the receiver pops: the front runs a three-stage
// pipeline (gaps, slope products, threshold compares) and the back resolves the
// one-bit dependency on the previous verdict. When the receiver stalls, verdicts
// collect in the inner queue and the output register; full rises once FIFO_DEPTH
// points are in flight ahead of the output. Reset clears all queues, loads the
// register defaults and starts a fresh ray. Configuration writes through cfg_we_i
// take effect at once and are meant to be made while no point is in flight.
module lidar_ray_ground_classifier #(
  parameter int unsigned FIFO_DEPTH = lrgc_pkg::FIFO_DEPTH_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [lrgc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [lrgc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                 push,
  output logic                                 full,
  input  logic [lrgc_pkg::RADIUS_W-1:0]        radius_i,
  input  logic signed [lrgc_pkg::HEIGHT_W-1:0] height_i,
  input  logic                                 first_of_ray_i,
  input  logic [lrgc_pkg::INDEX_W-1:0]         point_index_i,
  output logic                                 empty,
  input  logic                                 pop,
  output logic                                 is_ground_o,
  output logic [lrgc_pkg::INDEX_W-1:0]         index_out_o
);
  import lrgc_pkg::*;

  lrgc_cfg_t     cfg_q;
  logic          q_push, q_pop, q_empty;
  lrgc_verdict_t q_wdata, q_rdata;

  // Register file.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mount_height      <= MOUNT_HEIGHT_RST;
      cfg_q.local_slope_tan   <= LOCAL_SLOPE_TAN_RST;
      cfg_q.general_slope_tan <= GENERAL_SLOPE_TAN_RST;
      cfg_q.min_height_step   <= MIN_HEIGHT_STEP_RST;
      cfg_q.concentric_step   <= CONCENTRIC_STEP_RST;
      cfg_q.reclass_gap       <= RECLASS_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MOUNT_HEIGHT:      cfg_q.mount_height      <= cfg_wdata_i[LEN_W-1:0];
        REG_LOCAL_SLOPE_TAN:   cfg_q.local_slope_tan   <= cfg_wdata_i[SLOPE_W-1:0];
        REG_GENERAL_SLOPE_TAN: cfg_q.general_slope_tan <= cfg_wdata_i[SLOPE_W-1:0];
        REG_MIN_HEIGHT_STEP:   cfg_q.min_height_step   <= cfg_wdata_i[LEN_W-1:0];
        REG_CONCENTRIC_STEP:   cfg_q.concentric_step   <= cfg_wdata_i[LEN_W-1:0];
        REG_RECLASS_GAP:       cfg_q.reclass_gap       <= cfg_wdata_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  lrgc_front #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .push_i   (push),
    .full_o   (full),
    .radius_i (radius_i),
    .height_i (height_i),
    .first_i  (first_of_ray_i),
    .index_i  (point_index_i),
    .deq_i    (q_pop),
    .q_push_o (q_push),
    .q_data_o (q_wdata)
  );

  lrgc_queue #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  lrgc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (q_rdata),
    .q_pop_o     (q_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .is_ground_o (is_ground_o),
    .index_out_o (index_out_o)
  );

endmodule

// ===== hdl/lrgc_checker.sv =====
module lrgc_checker #(
  parameter int unsigned FIFO_DEPTH = lrgc_pkg::FIFO_DEPTH_DEF
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           push,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic                           is_ground_o,
  input logic [lrgc_pkg::INDEX_W-1:0]   index_out_o
);
  import lrgc_pkg::*;

  localparam int unsigned OUT_W = $clog2(FIFO_DEPTH + 3);

  // Points accepted whose verdicts have not yet left.
  logic [OUT_W-1:0] outstanding_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= '0;
    end else begin
      case ({push && !full, pop && !empty})
        2'b10:   outstanding_q <= outstanding_q + 1'b1;
        2'b01:   outstanding_q <= outstanding_q - 1'b1;
        default: outstanding_q <= outstanding_q;
      endcase
    end
  end

  // Reset leaves no verdict waiting and the input open by the following edge.
  a_reset_state: assert property (@(posedge clk_i) !rst_ni |=> empty && !full)
    else $error("queues not cleared in reset");

  // A waiting verdict holds until it is taken.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(is_ground_o) && $stable(index_out_o))
    else $error("waiting verdict changed");

  // No verdict shows without a point behind it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> outstanding_q != '0)
    else $error("verdict without accepted point");

  // The input closes only when the inner queue could otherwise overflow.
  a_full_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> outstanding_q >= OUT_W'(FIFO_DEPTH))
    else $error("input closed too early");

  // The block never holds more points than its queue and output register.
  a_capacity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    outstanding_q <= OUT_W'(FIFO_DEPTH + 1))
    else $error("more points in flight than storage");

endmodule

bind lidar_ray_ground_classifier lrgc_checker #(
  .FIFO_DEPTH(FIFO_DEPTH)
) u_lrgc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .push        (push),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .is_ground_o (is_ground_o),
  .index_out_o (index_out_o)
);
